>>> rtl/core/scf_pkg.sv
// Shared constants and types for the scale frame converter.
package scf_pkg;

	localparam int WEIGHT_CHARS = 6;
	localparam int FRAME_LEN    = 13;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_STX   = 8'h02;
	localparam logic [7:0] CH_ETX   = 8'h03;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_U     = 8'h55;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// Status bit positions in the byte after the carriage return.
	localparam int ST_RANGE_BIT  = 3;
	localparam int ST_STABLE_BIT = 4;

	typedef logic [WEIGHT_CHARS-1:0][7:0] wchars_t;
	typedef logic [FRAME_LEN-1:0][7:0]    frame_t;

	typedef struct packed {
		logic       stable;
		logic       range_err;
		logic [7:0] sign;
	} scf_hdr_t;

endpackage

>>> rtl/core/scale_frame_converter.sv
// Top level: scale serial byte parser with frame buffer and byte-serial output.
//
//  channel | signals                           | request
//  --------+-----------------------------------+--------------------------------
//  rx      | rx_valid, rx_stall, rx_byte       | one received scale byte
//  tx      | tx_valid, tx_stall, tx_byte,      | one output frame byte,
//          | frame_last                        | frame_last marks ETX
//
// An rx request is taken whenever rx_stall is low. The sixth weight byte builds the
// whole frame in that cycle into the frame buffer; the frame then leaves at one byte
// per cycle while tx_stall is low. rx stalls only on a sixth weight byte while the
// previous frame is still in the buffer. Reset puts the parser into carriage-return
// hunting and empties the buffer.
module scale_frame_converter import scf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       tx_valid,
	input  logic       tx_stall,
	output logic [7:0] tx_byte,
	output logic       frame_last
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_STATUS,
		PH_SIGN,
		PH_WEIGHT
	} phase_t;

	phase_t     phase_q;
	logic [2:0] count_q;
	scf_hdr_t   hdr_q;
	logic [7:0] wchr_q [WEIGHT_CHARS-1];
	frame_t     frame_q;
	logic [3:0] idx_q;
	logic       tx_valid_q;

	wchars_t    wchars_d;
	frame_t     frame_d;
	logic       rx_take;
	logic       tx_take;
	logic       complete;
	logic       tx_done;

	always_comb begin
		for (int i = 0; i < WEIGHT_CHARS - 1; i++) begin
			wchars_d[i] = wchr_q[i];
		end
		wchars_d[WEIGHT_CHARS-1] = rx_byte;
	end

	scf_frame_build u_build (
		.hdr    (hdr_q),
		.wchars (wchars_d),
		.frame  (frame_d)
	);

	assign complete   = (phase_q == PH_WEIGHT) && (count_q >= 3'(WEIGHT_CHARS - 1));
	assign tx_valid   = tx_valid_q;
	assign tx_byte    = frame_q[idx_q];
	assign frame_last = (idx_q == 4'(FRAME_LEN - 1));
	assign tx_take    = tx_valid_q && !tx_stall;
	assign tx_done    = tx_take && frame_last;
	assign rx_stall   = complete && tx_valid_q && !tx_done;
	assign rx_take    = rx_valid && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			count_q    <= '0;
			hdr_q      <= '0;
			tx_valid_q <= 1'b0;
			idx_q      <= '0;
		end else begin
			if (rx_take) begin
				case (phase_q)
					PH_HUNT: begin
						if (rx_byte == CH_CR) begin
							phase_q <= PH_STATUS;
						end
					end
					PH_STATUS: begin
						hdr_q.range_err <= rx_byte[ST_RANGE_BIT];
						hdr_q.stable    <= rx_byte[ST_STABLE_BIT];
						phase_q         <= PH_SIGN;
					end
					PH_SIGN: begin
						hdr_q.sign <= rx_byte;
						phase_q    <= PH_WEIGHT;
					end
					PH_WEIGHT: begin
						if (complete) begin
							count_q <= '0;
							phase_q <= PH_HUNT;
						end else begin
							count_q <= count_q + 3'd1;
						end
					end
					default: begin
						phase_q <= PH_HUNT;
					end
				endcase
			end

			if (rx_take && complete) begin
				tx_valid_q <= 1'b1;
				idx_q      <= '0;
			end else if (tx_take) begin
				if (frame_last) begin
					tx_valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take && (phase_q == PH_WEIGHT) && !complete) begin
			wchr_q[count_q] <= rx_byte;
		end
		if (rx_take && complete) begin
			frame_q <= frame_d;
		end
	end

endmodule

>>> rtl/core/scf_frame_build.sv
// Combinational builder of one 13-byte output frame from header and weight characters.
module scf_frame_build import scf_pkg::*; (
	input  scf_hdr_t hdr,
	input  wchars_t  wchars,
	output frame_t   frame
);

	logic       dot_found;
	logic [2:0] dot_pos;
	logic [2:0] dec_cnt;
	logic [7:0] chk;

	always_comb begin
		dot_found = 1'b0;
		dot_pos   = '0;
		for (int i = WEIGHT_CHARS - 1; i >= 0; i--) begin
			if (wchars[i] == CH_DOT) begin
				dot_found = 1'b1;
				dot_pos   = 3'(i);
			end
		end
		dec_cnt = 3'(WEIGHT_CHARS - 1) - dot_pos;

		frame[0] = CH_STX;
		frame[1] = CH_M;
		if (hdr.range_err) begin
			frame[2] = CH_F;
		end else if (hdr.stable) begin
			frame[2] = CH_S;
		end else begin
			frame[2] = CH_U;
		end
		frame[3] = dot_found ? (CH_ZERO + {5'b0, dec_cnt}) : CH_ZERO;
		frame[4] = (hdr.sign == CH_MINUS) ? CH_MINUS : CH_SPACE;

		// digits: chars before the first dot shift right by one, pad '0' on the left
		frame[5] = dot_found ? CH_ZERO : wchars[0];
		for (int j = 1; j < WEIGHT_CHARS; j++) begin
			if (dot_found && (3'(j) <= dot_pos)) begin
				frame[5 + j] = wchars[j - 1];
			end else begin
				frame[5 + j] = wchars[j];
			end
		end

		chk = '0;
		for (int k = 1; k <= 10; k++) begin
			chk = chk ^ frame[k];
		end
		frame[11] = chk;
		frame[12] = CH_ETX;
	end

endmodule

>>> verif/scf_checker.sv
// Scoreboard for the scale frame converter: tracks the parser, predicts frames, checks tx bytes.
`timescale 1ns / 100ps
module scf_checker import scf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	input  logic       rx_stall,
	input  logic [7:0] rx_byte,
	input  logic       tx_valid,
	input  logic       tx_stall,
	input  logic [7:0] tx_byte,
	input  logic       frame_last,
	output int         errors,
	output int         pending,
	output int         frames_done
);

	typedef enum logic [1:0] {HUNT, GET_STATUS, GET_SIGN, GET_WEIGHT} parse_ph_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	parse_ph_t   ph;
	logic [2:0]  wt_cnt;
	logic        stable;
	logic        range_err;
	logic [7:0]  sign;
	logic [7:0]  wt [WEIGHT_CHARS];
	frame_byte_t frame_q [$];

	task automatic note_fail(input string msg);
		errors++;
		if (errors <= 10)
			$display("[%0t] %s", $realtime, msg);
	endtask

	// Builds the 13-byte output frame from the latched header and weight characters.
	function automatic void queue_frame();
		logic [7:0]  fr [FRAME_LEN];
		logic [7:0]  chk;
		int          dot;
		int          pos;
		frame_byte_t fb;
		dot = -1;
		for (int i = 0; i < WEIGHT_CHARS; i++)
			if (dot < 0 && wt[i] == CH_DOT)
				dot = i;
		fr[0] = CH_STX;
		fr[1] = CH_M;
		fr[2] = range_err ? CH_F : (stable ? CH_S : CH_U);
		fr[3] = CH_ZERO + ((dot >= 0) ? 8'(WEIGHT_CHARS - 1 - dot) : 8'd0);
		fr[4] = (sign == CH_MINUS) ? CH_MINUS : CH_SPACE;
		for (int i = 5; i <= 10; i++)
			fr[i] = CH_ZERO;
		// first dot dropped, the rest right-aligned
		pos = 10;
		for (int i = WEIGHT_CHARS - 1; i >= 0; i--)
			if (i != dot) begin
				fr[pos] = wt[i];
				pos--;
			end
		chk = 8'h00;
		for (int i = 1; i <= 10; i++)
			chk = chk ^ fr[i];
		fr[11] = chk;
		fr[12] = CH_ETX;
		for (int i = 0; i < FRAME_LEN; i++) begin
			fb.data = fr[i];
			fb.last = (i == FRAME_LEN - 1);
			frame_q.push_back(fb);
		end
	endfunction

	always @(posedge clk) begin : mon
		frame_byte_t exp_b;
		if (!arst_n) begin
			ph = HUNT;
			wt_cnt = 3'd0;
			stable = 1'b0;
			range_err = 1'b0;
			sign = 8'h00;
			frame_q.delete();
		end else begin
			if (rx_valid && !rx_stall) begin
				case (ph)
					HUNT: begin
						if (rx_byte == CH_CR)
							ph = GET_STATUS;
					end
					GET_STATUS: begin
						range_err = rx_byte[ST_RANGE_BIT];
						stable = rx_byte[ST_STABLE_BIT];
						ph = GET_SIGN;
					end
					GET_SIGN: begin
						sign = rx_byte;
						ph = GET_WEIGHT;
					end
					default: begin
						wt[wt_cnt] = rx_byte;
						if (wt_cnt == 3'(WEIGHT_CHARS - 1)) begin
							queue_frame();
							frames_done++;
							wt_cnt = 3'd0;
							ph = HUNT;
						end else
							wt_cnt++;
					end
				endcase
			end
			if (tx_valid && !tx_stall) begin
				if (frame_q.size() == 0) begin
					note_fail($sformatf("unexpected tx byte %02h last %0b", tx_byte, frame_last));
				end else begin
					exp_b = frame_q.pop_front();
					if (tx_byte !== exp_b.data || frame_last !== exp_b.last)
						note_fail($sformatf("tx mismatch: expected %02h last %0b, got %02h last %0b",
							exp_b.data, exp_b.last, tx_byte, frame_last));
				end
			end
		end
		pending = frame_q.size();
	end

endmodule

>>> verif/tb_scale_frame_converter.sv
// Testbench top for the scale frame converter: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module tb_scale_frame_converter import scf_pkg::*;;

	localparam int N_REQUESTS  = 320;
	localparam int HOLD_CYCLES = 80;
	localparam int TAIL_CYCLES = 20;

	logic       clk;
	logic       arst_n;
	logic       rx_valid;
	logic       rx_stall;
	logic [7:0] rx_byte;
	logic       tx_valid;
	logic       tx_stall;
	logic [7:0] tx_byte;
	logic       frame_last;

	int errors;
	int pending;
	int frames_done;
	int sent;
	bit rx_gaps;
	bit tx_gaps;
	bit hold_go;

	scale_frame_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_byte   (rx_byte),
		.tx_valid  (tx_valid),
		.tx_stall  (tx_stall),
		.tx_byte   (tx_byte),
		.frame_last(frame_last)
	);

	scf_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_byte    (rx_byte),
		.tx_valid   (tx_valid),
		.tx_stall   (tx_stall),
		.tx_byte    (tx_byte),
		.frame_last (frame_last),
		.errors     (errors),
		.pending    (pending),
		.frames_done(frames_done)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#2_000_000;
		$display("** scale_frame_converter: FAILED **");
		$finish;
	end

	// receiver: random stalls, or a long hold-off on request
	initial begin
		tx_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				tx_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else
				tx_stall <= tx_gaps && ($urandom_range(99) < 33);
		end
	end

	// called and returns at a falling edge
	task automatic send_req(input logic [7:0] b);
		while (rx_gaps && $urandom_range(99) < 33) begin
			rx_valid <= 1'b0;
			@(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (rx_stall);
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [7:0] status, input logic [7:0] sgn,
		input logic [47:0] chars);
		send_req(CH_CR);
		send_req(status);
		send_req(sgn);
		for (int i = 0; i < WEIGHT_CHARS; i++)
			send_req(chars[47 - 8 * i -: 8]);
		sent += 3 + WEIGHT_CHARS;
	endtask

	function automatic logic [7:0] rand_wchar();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return CH_DOT;
		if (r < 22)
			return CH_CR;
		if (r < 37)
			return 8'($urandom);
		return CH_ZERO + 8'($urandom_range(9));
	endfunction

	initial begin : stim
		logic [47:0] chars;
		logic [7:0]  b;
		arst_n = 1'b0;
		rx_valid = 1'b0;
		rx_byte = 8'h00;
		rx_gaps = 1'b1;
		tx_gaps = 1'b1;
		hold_go = 1'b0;
		sent = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// noise while hunting, unused status bits, dot leading, repeated dot, CR as data
		send_req(8'hFF);
		send_req(8'h00);
		send_frame(8'hE7, CH_MINUS, ".12345");
		send_frame(8'h18, 8'hFF, {"1.2.3", CH_CR});
		send_frame(8'h10, 8'h2B, {"1234", 8'h00, 8'hFF});
		rx_valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);

		for (int f = 0; sent < N_REQUESTS; f++) begin
			if (f == 8) begin
				rx_valid <= 1'b0;
				wait (pending == 0);
				@(negedge clk);
			end
			if (f == 12) begin
				rx_gaps = 1'b0;
				hold_go = 1'b1;
			end
			if (f == 15)
				rx_gaps = 1'b1;
			if (f == 20) begin
				rx_gaps = 1'b0;
				tx_gaps = 1'b0;
			end
			if (f == 28) begin
				rx_gaps = 1'b1;
				tx_gaps = 1'b1;
			end
			if ($urandom_range(99) < 15)
				repeat ($urandom_range(1, 3)) begin
					b = 8'($urandom);
					if (b == CH_CR)
						b = ~b;
					send_req(b);
				end
			for (int k = 0; k < WEIGHT_CHARS; k++)
				chars = {chars[39:0], rand_wchar()};
			send_frame(8'($urandom), ($urandom_range(1) ? CH_MINUS : 8'($urandom)), chars);
		end
		rx_valid <= 1'b0;

		wait (pending == 0);
		@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Sent %0d frame requests, %0d frames predicted and checked byte by byte,",
			sent, frames_done);
		$display("including a receiver hold-off that backed up rx and a full drain pause.");
		if (errors == 0)
			$display("** scale_frame_converter: PASSED **");
		else
			$display("** scale_frame_converter: FAILED **");
		$finish;
	end

endmodule
